// ----- design/lcsl_pkg.sv -----
// shared types and constants for the longest common substring length block
package lcsl_pkg;

    localparam int SYM_W  = 8;
    localparam int OUT_W  = 7;
    localparam int OUT_SAT = (1 << OUT_W) - 1;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_COMPARE = 1'b1;

    typedef struct packed {
        logic             cmd;
        logic [SYM_W-1:0] symbol;
        logic             last;
    } t_in_req;

    typedef struct packed {
        logic [OUT_W-1:0] best_length;
        logic             overflow;
    } t_out_req;

    typedef struct packed {
        logic             compare;
        logic             clear;
        logic [SYM_W-1:0] symbol;
    } t_cell_ctl;

    typedef enum logic {
        ST_RUN,
        ST_DRAIN
    } t_state;

endpackage

// ----- design/lcsl_cell.sv -----
// one position of the stored string: symbol, run length, local best and max wave
module lcsl_cell import lcsl_pkg::*; #(
    parameter int RUN_W = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_ctl        i_ctl,
    input  logic             i_load,
    input  logic [RUN_W-1:0] i_run_prev,
    input  logic [RUN_W-1:0] i_max_prev,
    output logic [RUN_W-1:0] o_run,
    output logic [RUN_W-1:0] o_max
);

    logic [SYM_W-1:0] r_sym;
    logic             r_valid;
    logic [RUN_W-1:0] r_run;
    logic [RUN_W-1:0] r_best;
    logic [RUN_W-1:0] r_max;

    logic             n_valid;
    logic [RUN_W-1:0] n_run;
    logic [RUN_W-1:0] n_best;
    logic [RUN_W-1:0] n_max;

    always_comb begin
        n_valid = r_valid;
        n_run   = r_run;
        if (i_ctl.clear) begin
            n_valid = 1'b0;
            n_run   = '0;
        end else if (i_load) begin
            n_valid = 1'b1;
            n_run   = '0;
        end else if (i_ctl.compare) begin
            if (r_valid && (r_sym == i_ctl.symbol)) begin
                n_run = i_run_prev + RUN_W'(1);
            end else begin
                n_run = '0;
            end
        end
    end

    always_comb begin
        if (i_ctl.clear) begin
            n_best = '0;
            n_max  = '0;
        end else begin
            n_best = (n_run > r_best) ? n_run : r_best;
            n_max  = (i_max_prev > r_best) ? i_max_prev : r_best;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_run   <= '0;
            r_best  <= '0;
            r_max   <= '0;
        end else begin
            r_valid <= n_valid;
            r_run   <= n_run;
            r_best  <= n_best;
            r_max   <= n_max;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sym <= i_ctl.symbol;
        end
    end

    assign o_run = r_run;
    assign o_max = r_max;

endmodule

// ----- design/longest_common_substring_length.sv -----
// Longest common substring length of two byte strings. Requests with cmd 0
// store the first string, one byte per cell of a row of MAX_LEN cells; bytes
// beyond MAX_LEN are dropped and flag overflow. Requests with cmd 1 stream the
// second string: every cell updates its run length from its left neighbor,
// so a request is taken every cycle while loading or comparing.
// After the request marked last with cmd 1, the running maximum travels one
// cell per cycle along the row, and the block takes no request until it has
// reached the end of the row and the output register is free; it then presents
// best_length (saturated at 127) and overflow, and all state is cleared.
module longest_common_substring_length import lcsl_pkg::*; #(
    parameter int MAX_LEN = 64
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_req  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_out_req o_out_data
);

    localparam int RUN_W = $clog2(MAX_LEN + 1);
    localparam int CNT_W = $clog2(MAX_LEN + 1);

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] r_drain;
    logic [CNT_W-1:0] n_drain;
    logic             r_ovf;
    logic             n_ovf;
    logic             r_out_valid;
    logic             n_out_valid;
    t_out_req         r_out;
    t_out_req         n_out;

    logic             w_accept;
    logic             w_load;
    logic             w_compare;
    logic             w_full;
    logic             w_drained;
    logic             w_done;
    t_cell_ctl        w_ctl;
    logic [RUN_W-1:0] w_run [0:MAX_LEN];
    logic [RUN_W-1:0] w_max [0:MAX_LEN];
    logic [OUT_W-1:0] w_best;

    assign w_accept  = i_in_valid && o_in_ready;
    assign w_load    = w_accept && (i_in_data.cmd == CMD_LOAD);
    assign w_compare = w_accept && (i_in_data.cmd == CMD_COMPARE);
    assign w_full    = (r_count == CNT_W'(MAX_LEN));
    assign w_drained = (r_drain == CNT_W'(MAX_LEN));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_RUN: begin
                if (w_compare && i_in_data.last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (w_done) begin
                    n_state = ST_RUN;
                end
            end
            default: n_state = ST_RUN;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_ready = 1'b0;
        w_done     = 1'b0;
        case (r_state)
            ST_RUN: begin
                o_in_ready = 1'b1;
            end
            ST_DRAIN: begin
                w_done = w_drained && (!r_out_valid || i_out_ready);
            end
            default: begin
                o_in_ready = 1'b0;
                w_done     = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_count = r_count;
        n_ovf   = r_ovf;
        n_drain = r_drain;
        if (w_done) begin
            n_count = '0;
            n_ovf   = 1'b0;
            n_drain = '0;
        end else begin
            if (w_load) begin
                if (w_full) begin
                    n_ovf = 1'b1;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            if ((r_state == ST_DRAIN) && !w_drained) begin
                n_drain = r_drain + CNT_W'(1);
            end
        end
    end

    // saturate the final maximum to the result width
    always_comb begin
        if (32'(w_max[MAX_LEN]) > 32'(OUT_SAT)) begin
            w_best = OUT_W'(OUT_SAT);
        end else begin
            w_best = OUT_W'(w_max[MAX_LEN]);
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (w_done) begin
            n_out_valid       = 1'b1;
            n_out.best_length = w_best;
            n_out.overflow    = r_ovf;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_count     <= '0;
            r_drain     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_drain     <= n_drain;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign w_ctl.compare = w_compare;
    assign w_ctl.clear   = w_done;
    assign w_ctl.symbol  = i_in_data.symbol;

    assign w_run[0] = '0;
    assign w_max[0] = '0;

    for (genvar g = 0; g < MAX_LEN; g++) begin : g_cell
        lcsl_cell #(
            .RUN_W(RUN_W)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_load    (w_load && !w_full && (r_count == CNT_W'(g))),
            .i_run_prev(w_run[g]),
            .i_max_prev(w_max[g]),
            .o_run     (w_run[g+1]),
            .o_max     (w_max[g+1])
        );
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= MAX_LEN)
        else $error("stored length beyond capacity");

    a_last_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_compare && i_in_data.last) |=> (r_state == ST_DRAIN) && (r_drain == '0))
        else $error("last compare did not start the drain");

    a_load_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && !w_full) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("load did not advance the stored length");

    a_best_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_out_data.best_length) <= MAX_LEN))
        else $error("result longer than the store");

endmodule
